FILE: rtl/gpms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpms_pkg
// Shared widths, register codes and control types for the gapped path
// maximum-sum unit.
// ----------------------------------------------------------------------------
package gpms_pkg;

  localparam int AMOUNT_W = 20;
  localparam int SCORE_W = 48;
  localparam int GAP_W = 10;
  localparam int POS_W = 32;
  localparam int CFG_IDX_W = 1;

  localparam int HISTORY_DEPTH_DEF = 1024;

  localparam logic [GAP_W-1:0] MIN_GAP_RST = 10'd1;
  localparam logic [GAP_W-1:0] MAX_GAP_RST = 10'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP = 1'd1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic drop_head;
    logic drop_tail;
    logic push;
    logic finish;
  } gpms_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic front_expired;
    logic back_lower;
    logic admit;
    logic out_busy;
  } gpms_stat_t;

endpackage
`default_nettype wire

FILE: rtl/gpms_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpms_ctrl
// Sequencer for one request: expire old candidates from the deque front,
// drop weaker candidates from the back, push the new candidate, then score.
// ----------------------------------------------------------------------------
module gpms_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire gpms_pkg::gpms_stat_t stat,
  output gpms_pkg::gpms_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DROP,
    S_BACK,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // Take a request only between requests
  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DROP;
        end
      end
      S_DROP: begin
        if (stat.front_expired) begin
          cmd.drop_head = 1'b1;
        end else begin
          state_next = S_BACK;
        end
      end
      S_BACK: begin
        if (stat.back_lower) begin
          cmd.drop_tail = 1'b1;
        end else begin
          cmd.push = stat.admit;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/gpms_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpms_datapath
// Score history ring, candidate deque ring, position tracking, scoring with
// saturation, running maximum, configuration registers and result register.
// ----------------------------------------------------------------------------
module gpms_datapath #(
  parameter int HISTORY_DEPTH = gpms_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire gpms_pkg::gpms_cmd_t              cmd,
  output gpms_pkg::gpms_stat_t                  stat,
  input  wire logic [gpms_pkg::AMOUNT_W-1:0]    gold_amount,
  input  wire logic                             last_item,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [gpms_pkg::SCORE_W-1:0]          best_ending_here,
  output logic [gpms_pkg::SCORE_W-1:0]          best_so_far,
  output logic                                  is_last,
  input  wire logic                             cfg_we,
  input  wire logic [gpms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gpms_pkg::GAP_W-1:0]       cfg_data
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int LW = $clog2(HISTORY_DEPTH + 1);
  localparam int PW = gpms_pkg::POS_W;
  localparam int SW = gpms_pkg::SCORE_W;
  localparam int GW = gpms_pkg::GAP_W;
  localparam logic [AW:0] DEPTH_W = (AW+1)'(HISTORY_DEPTH);
  localparam logic [PW-1:0] LIM = PW'(HISTORY_DEPTH - 1);

  typedef struct packed {
    logic [PW-1:0] pos;
    logic [SW-1:0] score;
  } dq_entry_t;

  // Ring index arithmetic, operands below the depth
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_W) s = s - DEPTH_W;
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + DEPTH_W - {1'b0, b};
    if (s >= DEPTH_W) s = s - DEPTH_W;
    return s[AW-1:0];
  endfunction

  // Configuration
  logic [GW-1:0] min_gap;
  logic [GW-1:0] max_gap;
  logic [PW-1:0] lo_raw;
  logic [PW-1:0] hi_raw;
  logic [PW-1:0] lo;
  logic [PW-1:0] hi;

  // Sequence state
  logic [PW-1:0] pos;
  logic [AW-1:0] slot_k;
  logic [AW-1:0] jslot;
  logic [AW-1:0] head;
  logic [LW-1:0] len;
  logic [SW-1:0] running_best;
  logic          use_sj;

  // Request payload
  logic [gpms_pkg::AMOUNT_W-1:0] amount;
  logic                          last_r;

  // Memories
  logic [SW-1:0] hist_mem [HISTORY_DEPTH];
  dq_entry_t     dq_mem [HISTORY_DEPTH];
  logic [SW-1:0] hist_rd;
  dq_entry_t     rd_front;
  dq_entry_t     rd_back;

  // Next values and derived signals
  logic [PW-1:0] pos_next;
  logic [AW-1:0] slot_next;
  logic [AW-1:0] jslot_next;
  logic [AW-1:0] head_next;
  logic [LW-1:0] len_next;
  logic [LW-1:0] lenm1_next;
  logic [AW-1:0] tail_next;
  logic [AW-1:0] push_addr;
  logic [PW-1:0] front_age;
  logic [SW-1:0] prev;
  logic [SW:0]   sum;
  logic [SW-1:0] score;
  logic [SW-1:0] best_next;

  // Clip gaps to the history window
  always_comb begin
    lo_raw = (min_gap == '0) ? PW'(1) : PW'(min_gap);
    hi_raw = PW'(max_gap);
    lo = (lo_raw > LIM) ? LIM : lo_raw;
    hi = (hi_raw > LIM) ? LIM : hi_raw;
  end

  // Position and slot of the new request
  always_comb begin
    pos_next = pos + PW'(1);
    slot_next = (pos_next == '0) ? '0 : ring_add(slot_k, AW'(1));
    jslot_next = ring_sub(slot_next, lo[AW-1:0]);
  end

  // Deque pointer updates
  always_comb begin
    head_next = head;
    len_next = len;
    if (cmd.drop_head) begin
      head_next = ring_add(head, AW'(1));
      len_next = len - LW'(1);
    end
    if (cmd.drop_tail) begin
      len_next = len - LW'(1);
    end
    if (cmd.push) begin
      len_next = len + LW'(1);
    end
    if (cmd.finish && last_r) begin
      head_next = '0;
      len_next = '0;
    end
    lenm1_next = len_next - LW'(1);
    tail_next = ring_add(head_next, lenm1_next[AW-1:0]);
    push_addr = ring_add(head, len[AW-1:0]);
  end

  // Status toward the controller
  always_comb begin
    front_age = pos - rd_front.pos;
    stat.front_expired = (len != '0) && (front_age > hi);
    stat.admit = (pos > lo);
    stat.back_lower = stat.admit && (len != '0) && (rd_back.score < hist_rd);
    stat.out_busy = out_valid && out_stall;
  end

  // Score with saturation and running maximum
  always_comb begin
    prev = use_sj ? hist_rd : rd_front.score;
    sum = {1'b0, prev} + (SW+1)'(amount);
    if (len == '0) begin
      score = SW'(amount);
    end else if (sum[SW]) begin
      score = '1;
    end else begin
      score = sum[SW-1:0];
    end
    best_next = (score > running_best) ? score : running_best;
  end

  // Score history: written at scoring, read at the candidate slot
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hist_mem[slot_k] <= score;
    end
    hist_rd <= hist_mem[jslot];
  end

  // Candidate deque: one write, front and back reads
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      dq_mem[push_addr] <= '{pos: pos - lo, score: hist_rd};
    end
    rd_front <= dq_mem[head_next];
    rd_back <= dq_mem[tail_next];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap <= gpms_pkg::MIN_GAP_RST;
      max_gap <= gpms_pkg::MAX_GAP_RST;
      pos <= '0;
      slot_k <= '0;
      head <= '0;
      len <= '0;
      running_best <= '0;
      use_sj <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          gpms_pkg::CFG_MIN_GAP: min_gap <= cfg_data;
          gpms_pkg::CFG_MAX_GAP: max_gap <= cfg_data;
          default: ;
        endcase
      end
      head <= head_next;
      len <= len_next;
      if (cmd.load) begin
        pos <= pos_next;
        slot_k <= slot_next;
        use_sj <= 1'b0;
      end
      if (cmd.push) begin
        use_sj <= (len == '0);
      end
      if (cmd.finish) begin
        running_best <= last_r ? '0 : best_next;
        if (last_r) begin
          pos <= '0;
          slot_k <= '0;
        end
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      amount <= gold_amount;
      last_r <= last_item;
      jslot <= jslot_next;
    end
    if (cmd.finish) begin
      best_ending_here <= score;
      best_so_far <= best_next;
      is_last <= last_r;
    end
  end

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (len < LW'(HISTORY_DEPTH)))
    else $error("deque push with no room");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.drop_head || cmd.drop_tail) |-> (len != '0))
    else $error("deque pop while empty");

  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("result not presented after scoring");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, head} < DEPTH_W) && (len <= LW'(HISTORY_DEPTH)))
    else $error("deque pointer out of range");
`endif

endmodule
`default_nettype wire

FILE: rtl/gapped_path_max_sum_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gapped_path_max_sum_unit
// Maximum-sum chain with bounded gaps, scored one request at a time.
// ----------------------------------------------------------------------------
// Each request carries a value at the next position of a sequence and returns
// that position's score (value plus the best earlier score between min_gap and
// max_gap places back, saturating at 48 bits) together with the running
// maximum. A request moves from idle through the front-drop, back-drop and
// finish states, staying in a drop state while candidates leave the deque,
// and its scoring waits while an earlier result is still held at the output.
// Each candidate leaves the deque at most once. A request with last_item set
// ends the sequence and the state clears for the next one. The result
// register lets a new request enter while a result waits. Gaps are limited
// to HISTORY_DEPTH-1 and a zero min_gap acts as 1. Configuration must be
// written only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module gapped_path_max_sum_unit #(
  parameter int HISTORY_DEPTH = gpms_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [gpms_pkg::AMOUNT_W-1:0]    gold_amount,
  input  wire logic                             last_item,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [gpms_pkg::SCORE_W-1:0]          best_ending_here,
  output logic [gpms_pkg::SCORE_W-1:0]          best_so_far,
  output logic                                  is_last,
  input  wire logic                             cfg_we,
  input  wire logic [gpms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gpms_pkg::GAP_W-1:0]       cfg_data
);

  gpms_pkg::gpms_cmd_t  cmd;
  gpms_pkg::gpms_stat_t stat;

  // Sequencer
  gpms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and arithmetic
  gpms_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .gold_amount      (gold_amount),
    .last_item        (last_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .best_ending_here (best_ending_here),
    .best_so_far      (best_so_far),
    .is_last          (is_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

endmodule
`default_nettype wire

FILE: verif/gpms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpms_checker
// Watches the request and result channels of the gapped path max-sum unit.
// It scores every accepted request with its own window-maximum deque, queues
// the expected result, and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module gpms_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [gpms_pkg::AMOUNT_W-1:0]  gold_amount,
  input  logic                           last_item,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [gpms_pkg::SCORE_W-1:0]   best_ending_here,
  input  logic [gpms_pkg::SCORE_W-1:0]   best_so_far,
  input  logic                           is_last,
  input  logic                           cfg_we,
  input  logic [gpms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gpms_pkg::GAP_W-1:0]     cfg_data,
  output int                             mismatch_count,
  output int                             scores_pending
);
  import gpms_pkg::*;

  localparam int unsigned DEPTH = HISTORY_DEPTH_DEF;
  localparam logic [SCORE_W-1:0] SCORE_SAT = '1;

  typedef struct packed {
    logic [SCORE_W-1:0] here;
    logic [SCORE_W-1:0] so_far;
    logic               last;
  } score_rec_t;

  // Shadow copy of the registers and the sequence state
  logic [GAP_W-1:0]   min_gap_q;
  logic [GAP_W-1:0]   max_gap_q;
  logic [SCORE_W-1:0] score_mem [DEPTH];
  logic [POS_W-1:0]   cand_mem [DEPTH];
  int unsigned        dq_head;
  int unsigned        dq_len;
  logic [POS_W-1:0]   position;
  logic [SCORE_W-1:0] running_best;

  score_rec_t scores_due[$];
  int         errors = 0;

  assign mismatch_count = errors;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  function automatic void clear_sequence();
    for (int i = 0; i < DEPTH; i++) begin
      score_mem[i] = '0;
      cand_mem[i] = '0;
    end
    dq_head = 0;
    dq_len = 0;
    position = '0;
    running_best = '0;
  endfunction

  // Score one request at the next position and advance the deque
  function automatic score_rec_t score_position(input logic [AMOUNT_W-1:0] amount,
                                                input logic last);
    logic [POS_W-1:0]   lo;
    logic [POS_W-1:0]   hi;
    logic [POS_W-1:0]   k;
    logic [POS_W-1:0]   j;
    logic [POS_W-1:0]   age;
    logic [SCORE_W-1:0] amt_w;
    logic [SCORE_W-1:0] sj;
    logic [SCORE_W-1:0] prev;
    logic [SCORE_W-1:0] score;
    score_rec_t         rec;
    lo = (min_gap_q == '0) ? 32'd1 : 32'(min_gap_q);
    hi = 32'(max_gap_q);
    if (lo > DEPTH - 1) lo = DEPTH - 1;
    if (hi > DEPTH - 1) hi = DEPTH - 1;
    position = position + 1'b1;
    k = position;

    // drop candidates that fell out of the window
    while (dq_len > 0) begin
      age = k - cand_mem[dq_head];
      if (age <= hi) break;
      dq_head = (dq_head + 1) % DEPTH;
      dq_len--;
    end

    // admit the position min_gap back, keeping scores non-increasing
    if (k > lo) begin
      j = k - lo;
      sj = score_mem[j % DEPTH];
      while (dq_len > 0 &&
             score_mem[cand_mem[(dq_head + dq_len - 1) % DEPTH] % DEPTH] < sj)
        dq_len--;
      if (dq_len < DEPTH) begin
        cand_mem[(dq_head + dq_len) % DEPTH] = j;
        dq_len++;
      end
    end

    amt_w = SCORE_W'(amount);
    score = amt_w;
    if (dq_len > 0) begin
      prev = score_mem[cand_mem[dq_head] % DEPTH];
      score = (prev > SCORE_SAT - amt_w) ? SCORE_SAT : prev + amt_w;
    end
    score_mem[k % DEPTH] = score;
    if (score > running_best) running_best = score;

    rec.here = score;
    rec.so_far = running_best;
    rec.last = last;
    if (last) clear_sequence();
    return rec;
  endfunction

  // Compare results, then queue predictions, then track register writes
  always @(posedge clk) begin
    score_rec_t want;
    if (rst) begin
      scores_due.delete();
      min_gap_q = MIN_GAP_RST;
      max_gap_q = MAX_GAP_RST;
      clear_sequence();
    end else begin
      if (out_valid && !out_stall) begin
        if (scores_due.size() == 0) begin
          report_mismatch($sformatf("result with none expected (here=%0d so_far=%0d)",
                                    best_ending_here, best_so_far));
        end else begin
          want = scores_due[0];
          scores_due.delete(0);
          if (best_ending_here !== want.here)
            report_mismatch($sformatf("best_ending_here got %0d want %0d",
                                      best_ending_here, want.here));
          if (best_so_far !== want.so_far)
            report_mismatch($sformatf("best_so_far got %0d want %0d",
                                      best_so_far, want.so_far));
          if (is_last !== want.last)
            report_mismatch($sformatf("is_last got %b want %b", is_last, want.last));
        end
      end
      if (in_valid && !in_stall)
        scores_due = {scores_due, score_position(gold_amount, last_item)};
      if (cfg_we) begin
        if (cfg_index == CFG_MIN_GAP) min_gap_q = cfg_data;
        else if (cfg_index == CFG_MAX_GAP) max_gap_q = cfg_data;
      end
    end
    scores_pending <= scores_due.size();
  end

endmodule

FILE: verif/gapped_path_max_sum_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gapped_path_max_sum_unit_test
// Drives sequences of values into the gapped path max-sum unit across a
// series of gap settings and idle patterns, with a long result hold-off to
// back the unit up, and reports the verdict from the attached checker.
// ----------------------------------------------------------------------------
module gapped_path_max_sum_unit_test;
  import gpms_pkg::*;

  localparam int NUM_PHASES = 14;
  localparam int PRESSURE_PHASE = 4;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES = 50;
  localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = '1;

  typedef enum int {SHAPE_NOISE, SHAPE_RISE, SHAPE_FALL, SHAPE_FLAT} shape_t;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic [AMOUNT_W-1:0]  gold_amount = '0;
  logic                 last_item = 1'b0;
  logic                 out_stall = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_GAP;
  logic [GAP_W-1:0]     cfg_data = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic [SCORE_W-1:0]   best_ending_here;
  logic [SCORE_W-1:0]   best_so_far;
  logic                 is_last;

  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_trigger = 1'b0;
  bit  hold_taken = 1'b0;
  int  hold_left = 0;
  int  mismatch_count;
  int  scores_pending;

  // Gap settings, request counts and sequence lengths per random phase
  int ph_min [NUM_PHASES] = '{1, 0, 3, 7, 2, 1, 200, 1023, 5, 0, 1023, 4, 1, 0};
  int ph_max [NUM_PHASES] = '{1, 5, 10, 3, 40, 1023, 1023, 1023, 5, 0, 1, 12, 2, 1023};
  int ph_reqs [NUM_PHASES] = '{100, 100, 100, 100, 100, 200, 200, 60, 100, 100, 100,
                               100, 100, 100};
  int ph_lo [NUM_PHASES] = '{1, 1, 1, 1, 1, 50, 220, 1, 1, 1, 1, 1, 1, 1};
  int ph_hi [NUM_PHASES] = '{12, 30, 40, 20, 60, 200, 260, 30, 15, 10, 20, 40, 8, 100};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gapped_path_max_sum_unit dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .gold_amount      (gold_amount),
    .last_item        (last_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .best_ending_here (best_ending_here),
    .best_so_far      (best_so_far),
    .is_last          (is_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  gpms_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .gold_amount      (gold_amount),
    .last_item        (last_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .best_ending_here (best_ending_here),
    .best_so_far      (best_so_far),
    .is_last          (is_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .scores_pending   (scores_pending)
  );

  // Result side: random stalls, plus one long hold-off when triggered
  always @(posedge clk) begin
    if (hold_trigger && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one request, idling first at random, and wait for acceptance
  task automatic send_item(input logic [AMOUNT_W-1:0] amount, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    gold_amount <= amount;
    last_item <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Write one register, then lower the write enable again before returning
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAP_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Hold off requests until every expected result has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (scores_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        idle_pct = 0;
        stall_pct <= 0;
      end
      IDLE_SENDER: begin
        idle_pct = 62;
        stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        idle_pct = 0;
        stall_pct <= 62;
      end
      default: begin
        idle_pct = 24;
        stall_pct <= 24;
      end
    endcase
  endtask

  function automatic logic [AMOUNT_W-1:0] next_amount(input logic [AMOUNT_W-1:0] prev,
                                                      input shape_t shape);
    logic [AMOUNT_W-1:0] step;
    int                  roll;
    step = AMOUNT_W'($urandom_range(15));
    roll = $urandom_range(9);
    case (shape)
      SHAPE_RISE: return (prev > AMOUNT_MAX - step) ? prev : prev + step;
      SHAPE_FALL: return (prev < step) ? prev : prev - step;
      SHAPE_FLAT: return AMOUNT_W'($urandom_range(3));
      default: begin
        if (roll == 0) return '0;
        if (roll == 1) return AMOUNT_MAX;
        return AMOUNT_W'($urandom);
      end
    endcase
  endfunction

  // Send one whole sequence of random shape, ending in last_item
  task automatic send_sequence(input int len);
    shape_t              shape;
    logic [AMOUNT_W-1:0] amount;
    shape = shape_t'($urandom_range(3));
    amount = AMOUNT_W'($urandom);
    for (int i = 1; i <= len; i++) begin
      if ($urandom_range(15) == 0) shape = shape_t'($urandom_range(3));
      amount = next_amount(amount, shape);
      send_item(amount, i == len);
    end
  endtask

  initial begin
    int sent;
    int len;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset gaps: field extremes, single-item sequence, falling values
    send_item(20'hFFFFF, 1'b0);
    send_item(20'h00000, 1'b0);
    send_item(20'hAAAAA, 1'b0);
    send_item(20'h55555, 1'b0);
    send_item(20'hFFFFF, 1'b0);
    send_item(20'h00001, 1'b0);
    send_item(20'hFFFFF, 1'b1);
    send_item(20'h12345, 1'b1);
    send_item(20'd9, 1'b0);
    send_item(20'd8, 1'b0);
    send_item(20'd7, 1'b0);
    send_item(20'd6, 1'b0);
    send_item(20'd5, 1'b1);

    // Zero min_gap acts as one
    settle();
    write_reg(CFG_MIN_GAP, 10'd0);
    write_reg(CFG_MAX_GAP, 10'd3);
    send_item(20'd3, 1'b0);
    send_item(20'd5, 1'b0);
    send_item(20'd1, 1'b0);
    send_item(20'd7, 1'b0);
    send_item(20'd2, 1'b1);

    // min_gap above max_gap leaves a single predecessor
    settle();
    write_reg(CFG_MIN_GAP, 10'd4);
    write_reg(CFG_MAX_GAP, 10'd2);
    for (int i = 1; i <= 6; i++) send_item(AMOUNT_W'(i), i == 6);

    // Random phases over the gap settings and idle patterns
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_reg(CFG_MIN_GAP, GAP_W'(ph_min[p]));
      write_reg(CFG_MAX_GAP, GAP_W'(ph_max[p]));
      set_idle(idle_mode_t'(p % 4));
      if (p == PRESSURE_PHASE) hold_trigger <= 1'b1;
      sent = 0;
      while (sent < ph_reqs[p]) begin
        len = $urandom_range(ph_hi[p], ph_lo[p]);
        send_sequence(len);
        sent += len;
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && scores_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
